/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands; they expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLIES(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

/* hdl/pid_pkg.sv */
// ----------------------------------------------------------------------------
// pid_pkg
// Shared constants, register codes and types of the PID controller.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Multiplier operand digit consumed per cycle.
  localparam int MUL_DIGIT = 16;

  localparam int REG_INDEX_WIDTH = 3;

  localparam logic [REG_INDEX_WIDTH-1:0] REG_DEADBAND   = 3'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_KP         = 3'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_KI_TS      = 3'd2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_KD_OVER_TS = 3'd3;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_D_ALPHA    = 3'd4;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_D_MAX      = 3'd5;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_OUT_MIN    = 3'd6;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_OUT_MAX    = 3'd7;

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_MAX  = 2'd1;
  localparam logic [1:0] HIT_MIN  = 2'd2;

  typedef struct packed {
    logic start;
    logic wide;   // saturate to DATA_WIDTH+2 bits instead of DATA_WIDTH
  } mul_ctl_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

/* hdl/pid_controller_antiwindup.sv */
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Sequencing: a request is taken only in the idle state, after the last one
//   has left the limit stage; each request takes four passes through the
//   one shared multiplier. A new request is taken while a result waits.
// Reset: synchronous, clears integral, filter and previous error state and
//   loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pid_controller_antiwindup #(
  parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pid_pkg::FRAC_BITS_DEF,
  localparam int CFG_W     = pid_pkg::imax(DATA_WIDTH, FRAC_BITS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pid_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_W-1:0]                    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [DATA_WIDTH-1:0]        error,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DATA_WIDTH-1:0]        drive,
  output logic [1:0]                          limit_hit
);

  localparam int W  = DATA_WIDTH;
  localparam int XW = W + 2;
  localparam int BW = pid_pkg::imax(W, FRAC_BITS + 2);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DB   = 4'd1;
  localparam logic [3:0] ST_X    = 4'd2;
  localparam logic [3:0] ST_WF   = 4'd3;
  localparam logic [3:0] ST_FC   = 4'd4;
  localparam logic [3:0] ST_WD   = 4'd5;
  localparam logic [3:0] ST_WP   = 4'd6;
  localparam logic [3:0] ST_WI   = 4'd7;
  localparam logic [3:0] ST_SUM  = 4'd8;
  localparam logic [3:0] ST_LIM  = 4'd9;

  localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

  // configuration
  logic [W-2:0]          cfg_deadband;
  logic signed [W-1:0]   cfg_kp;
  logic signed [W-1:0]   cfg_ki_ts;
  logic signed [W-1:0]   cfg_kd;
  logic [FRAC_BITS:0]    cfg_alpha;
  logic [W-2:0]          cfg_d_max;
  logic signed [W-1:0]   cfg_out_min;
  logic signed [W-1:0]   cfg_out_max;

  // sequencer and data path
  logic [3:0]            state;
  logic [3:0]            state_next;
  logic signed [W-1:0]   err_q;
  logic signed [W-1:0]   e_q;
  logic signed [W-1:0]   prev;
  logic signed [W-1:0]   fdiff;
  logic signed [W-1:0]   integ;
  logic signed [W+2:0]   fsum;
  logic signed [W-1:0]   p_q;
  logic signed [W-1:0]   d_q;
  logic signed [W-1:0]   ni_q;
  logic signed [W:0]     pd_q;
  logic signed [W+1:0]   y_q;

  // shared multiplier
  pid_pkg::mul_ctl_t     mul_ctl;
  logic signed [XW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic                  mul_done;
  logic signed [XW-1:0]  mul_res;

  logic signed [W:0]     errx;
  logic signed [W:0]     dbx;
  logic                  in_band;
  logic signed [XW-1:0]  x_c;
  logic signed [W+2:0]   dmx;
  logic signed [W+2:0]   fclamp_wide;
  logic signed [W-1:0]   f_clamp;
  logic signed [W:0]     isum;
  logic signed [W-1:0]   isat;
  logic                  out_free;
  logic                  hit_max;
  logic                  hit_min;
  logic signed [W-1:0]   lim_val;
  logic signed [W+1:0]   ldiff;
  logic signed [W-1:0]   lsat;

  pid_regs #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .deadband   (cfg_deadband),
    .kp         (cfg_kp),
    .ki_ts      (cfg_ki_ts),
    .kd_over_ts (cfg_kd),
    .alpha_eff  (cfg_alpha),
    .d_max      (cfg_d_max),
    .out_min    (cfg_out_min),
    .out_max    (cfg_out_max)
  );

  pid_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .res  (mul_res)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // deadband
  assign errx    = (W+1)'(err_q);
  assign dbx     = $signed({2'b00, cfg_deadband});
  assign in_band = (errx >= -dbx) && (errx <= dbx);

  // filter input: (e - prev) - f
  assign x_c = XW'(e_q) - XW'(prev) - XW'(fdiff);

  // derivative clamp
  assign dmx         = $signed({4'b0000, cfg_d_max});
  assign fclamp_wide = (fsum > dmx) ? dmx : ((fsum < -dmx) ? -dmx : fsum);
  assign f_clamp     = fclamp_wide[W-1:0];

  // integral update, saturated
  assign isum = (W+1)'(integ) + (W+1)'($signed(mul_res[W-1:0]));
  assign isat = (isum[W] != isum[W-1]) ? (isum[W] ? W_MIN : W_MAX) : isum[W-1:0];

  // output limits, upper limit tested first
  assign hit_max = (y_q > (W+2)'(cfg_out_max));
  assign hit_min = (y_q < (W+2)'(cfg_out_min));
  assign lim_val = hit_max ? cfg_out_max : cfg_out_min;
  assign ldiff   = (W+2)'(lim_val) - (W+2)'(pd_q);
  assign lsat    = ((ldiff[W+1:W-1] == 3'b000) || (ldiff[W+1:W-1] == 3'b111))
                   ? ldiff[W-1:0] : (ldiff[W+1] ? W_MIN : W_MAX);

  always_comb begin
    mul_ctl.start = 1'b0;
    mul_ctl.wide  = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state)
      ST_X: begin
        mul_ctl.start = 1'b1;
        mul_ctl.wide  = 1'b1;
        mul_a         = x_c;
        mul_b         = $signed(BW'(cfg_alpha));
      end
      ST_FC: begin
        mul_ctl.start = 1'b1;
        mul_a         = XW'(f_clamp);
        mul_b         = BW'(cfg_kd);
      end
      ST_WD: begin
        mul_ctl.start = mul_done;
        mul_a         = XW'(e_q);
        mul_b         = BW'(cfg_kp);
      end
      ST_WP: begin
        mul_ctl.start = mul_done;
        mul_a         = XW'(e_q);
        mul_b         = BW'(cfg_ki_ts);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DB;
      ST_DB:   state_next = ST_X;
      ST_X:    state_next = ST_WF;
      ST_WF:   if (mul_done) state_next = ST_FC;
      ST_FC:   state_next = ST_WD;
      ST_WD:   if (mul_done) state_next = ST_WP;
      ST_WP:   if (mul_done) state_next = ST_WI;
      ST_WI:   if (mul_done) state_next = ST_SUM;
      ST_SUM:  state_next = ST_LIM;
      ST_LIM:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev  <= '0;
      fdiff <= '0;
      integ <= '0;
    end else begin
      if (state == ST_FC) begin
        fdiff <= f_clamp;
      end
      if (state == ST_LIM && out_free) begin
        prev  <= e_q;
        integ <= (hit_max || hit_min) ? lsat : ni_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      err_q <= error;
    end
    if (state == ST_DB) begin
      e_q <= in_band ? '0 : err_q;
    end
    if (state == ST_WF && mul_done) begin
      fsum <= (W+3)'(fdiff) + (W+3)'(mul_res);
    end
    if (state == ST_WD && mul_done) begin
      d_q <= mul_res[W-1:0];
    end
    if (state == ST_WP && mul_done) begin
      p_q <= mul_res[W-1:0];
    end
    if (state == ST_WI && mul_done) begin
      ni_q <= isat;
    end
    if (state == ST_SUM) begin
      pd_q <= (W+1)'(p_q) + (W+1)'(d_q);
      y_q  <= (W+2)'(p_q) + (W+2)'(d_q) + (W+2)'(ni_q);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_LIM && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LIM && out_free) begin
      if (hit_max) begin
        drive     <= cfg_out_max;
        limit_hit <= pid_pkg::HIT_MAX;
      end else if (hit_min) begin
        drive     <= cfg_out_min;
        limit_hit <= pid_pkg::HIT_MIN;
      end else begin
        drive     <= y_q[W-1:0];
        limit_hit <= pid_pkg::HIT_NONE;
      end
    end
  end

  `ASSERT_CLK(a_busy_after_request, in_valid && in_ready |=> !in_ready, "request taken while busy")
  `ASSERT_IMPLIES(a_done_in_wait, mul_done, state == ST_WF || state == ST_WD || state == ST_WP || state == ST_WI, "multiplier done outside a wait state")
  `ASSERT_IMPLIES(a_hit_code, out_valid, limit_hit == pid_pkg::HIT_NONE || limit_hit == pid_pkg::HIT_MAX || limit_hit == pid_pkg::HIT_MIN, "bad limit code")
  `ASSERT_IMPLIES(a_max_drive, out_valid && limit_hit == pid_pkg::HIT_MAX, drive == cfg_out_max, "clamped drive differs from upper limit")

endmodule

/* hdl/pid_regs.sv */
// ----------------------------------------------------------------------------
// pid_regs
// Configuration register file with write decode and filter weight limiting.
// ----------------------------------------------------------------------------
module pid_regs #(
  parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pid_pkg::FRAC_BITS_DEF,
  localparam int CFG_W     = pid_pkg::imax(DATA_WIDTH, FRAC_BITS + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pid_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                     cfg_data,
  output logic [DATA_WIDTH-2:0]                deadband,
  output logic signed [DATA_WIDTH-1:0]         kp,
  output logic signed [DATA_WIDTH-1:0]         ki_ts,
  output logic signed [DATA_WIDTH-1:0]         kd_over_ts,
  output logic [FRAC_BITS:0]                   alpha_eff,
  output logic [DATA_WIDTH-2:0]                d_max,
  output logic signed [DATA_WIDTH-1:0]         out_min,
  output logic signed [DATA_WIDTH-1:0]         out_max
);

  localparam logic [FRAC_BITS:0] ALPHA_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic [FRAC_BITS:0] d_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband   <= '0;
      kp         <= '0;
      ki_ts      <= '0;
      kd_over_ts <= '0;
      d_alpha    <= ALPHA_ONE;
      d_max      <= '1;
      out_min    <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      out_max    <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (cfg_write) begin
      unique case (cfg_index)
        pid_pkg::REG_DEADBAND:   deadband   <= cfg_data[DATA_WIDTH-2:0];
        pid_pkg::REG_KP:         kp         <= cfg_data[DATA_WIDTH-1:0];
        pid_pkg::REG_KI_TS:      ki_ts      <= cfg_data[DATA_WIDTH-1:0];
        pid_pkg::REG_KD_OVER_TS: kd_over_ts <= cfg_data[DATA_WIDTH-1:0];
        pid_pkg::REG_D_ALPHA:    d_alpha    <= cfg_data[FRAC_BITS:0];
        pid_pkg::REG_D_MAX:      d_max      <= cfg_data[DATA_WIDTH-2:0];
        pid_pkg::REG_OUT_MIN:    out_min    <= cfg_data[DATA_WIDTH-1:0];
        pid_pkg::REG_OUT_MAX:    out_max    <= cfg_data[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Weights above one act as one.
  assign alpha_eff = (d_alpha > ALPHA_ONE) ? ALPHA_ONE : d_alpha;

endmodule

/* hdl/pid_mul.sv */
// ----------------------------------------------------------------------------
// pid_mul
// Shared sign-magnitude multiplier: digit-serial product, round to nearest
// with ties away from zero, shift by the fraction bits, saturate.
// ----------------------------------------------------------------------------
module pid_mul #(
  parameter int DATA_WIDTH = pid_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pid_pkg::FRAC_BITS_DEF,
  localparam int XW        = DATA_WIDTH + 2,
  localparam int BW        = pid_pkg::imax(DATA_WIDTH, FRAC_BITS + 2)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pid_pkg::mul_ctl_t       ctl,
  input  logic signed [XW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic                    done,
  output logic signed [XW-1:0]    res
);

  localparam int DIG   = pid_pkg::MUL_DIGIT;
  localparam int NSTEP = (BW + DIG - 1) / DIG;
  localparam int BP    = NSTEP * DIG;
  localparam int PW    = XW + BP;
  localparam int QW    = PW - FRAC_BITS;
  localparam int CW    = $clog2(NSTEP) + 1;
  localparam logic [PW-1:0] RND_HALF = PW'(1) << (FRAC_BITS - 1);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RUN  = 2'd1;
  localparam logic [1:0] M_RND  = 2'd2;
  localparam logic [1:0] M_SAT  = 2'd3;

  logic [1:0]          mstate;
  logic [CW-1:0]       cnt;
  logic                neg;
  logic                wide;
  logic [XW-1:0]       ua;
  logic [BP-1:0]       ub;
  logic [PW-1:0]       acc;
  logic [QW-1:0]       q;

  logic [XW-1:0]       amag;
  logic [BW-1:0]       bmag;
  logic [XW+DIG-1:0]   pp;
  logic [QW-1:0]       lim;
  logic [QW-1:0]       qsat;

  assign amag = a[XW-1] ? XW'(-a) : XW'(a);
  assign bmag = b[BW-1] ? BW'(-b) : BW'(b);
  assign pp   = ua * ub[BP-1 -: DIG];

  assign lim  = (wide ? (QW'(1) << (XW - 1)) : (QW'(1) << (DATA_WIDTH - 1)))
                - QW'(!neg);
  assign qsat = (q > lim) ? lim : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
      done   <= 1'b0;
    end else begin
      done <= (mstate == M_SAT);
      unique case (mstate)
        M_IDLE: if (ctl.start) mstate <= M_RUN;
        M_RUN:  if (cnt == CW'(NSTEP - 1)) mstate <= M_RND;
        M_RND:  mstate <= M_SAT;
        M_SAT:  mstate <= M_IDLE;
        default: mstate <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (mstate)
      M_IDLE: begin
        cnt  <= '0;
        neg  <= a[XW-1] ^ b[BW-1];
        wide <= ctl.wide;
        ua   <= amag;
        ub   <= BP'(bmag);
        acc  <= '0;
      end
      M_RUN: begin
        // Most significant digit first.
        acc <= (acc << DIG) + PW'(pp);
        ub  <= ub << DIG;
        cnt <= cnt + CW'(1);
      end
      M_RND: q <= QW'((acc + RND_HALF) >> FRAC_BITS);
      M_SAT: res <= neg ? -$signed(XW'(qsat)) : $signed(XW'(qsat));
      default: ;
    endcase
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the anti-windup PID controller. Error samples
// go in through a bursty valid/ready sender. A bit-accurate controller
// model predicts drive and limit flag for every accepted sample, and the
// results are checked in order against a stalling receiver. Gains,
// filter and limits are reloaded between phases, including the extreme
// settings.
// ----------------------------------------------------------------------------
module tb_top;
  import pid_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int CW = (DW > FB + 1) ? DW : FB + 1;
  localparam longint WMAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;
  localparam longint ONE_Q = longint'(1) << FB;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic [1:0]           hit;
  } control_out_t;

  typedef struct packed {
    logic [DW-1:0] err;
    logic          drain_first;
  } error_req_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [REG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CW-1:0]              cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [DW-1:0]       error = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [DW-1:0]       drive;
  logic [1:0]                 limit_hit;

  // Register copies and controller state of the model
  longint db_cfg = 0, kp_cfg = 0, ki_cfg = 0, kd_cfg = 0;
  longint alpha_cfg = ONE_Q, dmax_cfg = WMAX, omin_cfg = WMIN, omax_cfg = WMAX;
  longint integ_acc = 0, filt_diff = 0, prev_err = 0;

  error_req_t   error_queue[$];
  control_out_t expected_out[$];
  int           fail_count = 0;

  bit            tx_steady = 1'b0;
  bit            rx_steady = 1'b0;
  int            holds_asked = 0;
  logic [DW-1:0] ramp_err = '0;

  int           gap_left, burst_left;
  int           rx_left, hold_left, holds_done;
  int           idle_cycles;
  logic         offering;
  error_req_t   next_req;
  control_out_t want;

  pid_controller_antiwindup dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .error     (error),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .limit_hit (limit_hit)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endtask

  // round(a*b / 2^FB) with ties away from zero, saturated to sbits signed
  function automatic longint mul_round_sat(input longint a, input longint b, input int sbits);
    logic [127:0] mag, lim;
    logic neg;
    neg = (a < 0) != (b < 0);
    mag = 128'((a < 0) ? -a : a) * 128'((b < 0) ? -b : b);
    mag = (mag + (128'(1) << (FB - 1))) >> FB;
    lim = (128'(1) << (sbits - 1)) - (neg ? 128'(0) : 128'(1));
    if (mag > lim) mag = lim;
    return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
  endfunction

  function automatic longint sat_word(input longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  task automatic pid_predict(input logic signed [DW-1:0] err_in);
    longint e, p, d, f, ni, y, alpha;
    control_out_t res;
    e = longint'(err_in);
    if (e >= -db_cfg && e <= db_cfg) e = 0;
    alpha = (alpha_cfg > ONE_Q) ? ONE_Q : alpha_cfg;
    p = mul_round_sat(kp_cfg, e, DW);
    f = filt_diff + mul_round_sat((e - prev_err) - filt_diff, alpha, DW + 2);
    if (f > dmax_cfg) f = dmax_cfg;
    else if (f < -dmax_cfg) f = -dmax_cfg;
    filt_diff = f;
    d = mul_round_sat(f, kd_cfg, DW);
    prev_err = e;
    ni = sat_word(integ_acc + mul_round_sat(e, ki_cfg, DW));
    y = p + d + ni;
    res.hit = HIT_NONE;
    // upper limit wins when the limits are crossed
    if (y > omax_cfg) begin
      y = omax_cfg;
      res.hit = HIT_MAX;
      integ_acc = sat_word(y - (p + d));
    end else if (y < omin_cfg) begin
      y = omin_cfg;
      res.hit = HIT_MIN;
      integ_acc = sat_word(y - (p + d));
    end else begin
      integ_acc = ni;
    end
    res.drive = y[DW-1:0];
    expected_out.push_back(res);
  endtask

  task automatic set_reg(input logic [REG_INDEX_WIDTH-1:0] idx, input logic [CW-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DEADBAND:   db_cfg = longint'(val[DW-2:0]);
      REG_KP:         kp_cfg = longint'(signed'(val[DW-1:0]));
      REG_KI_TS:      ki_cfg = longint'(signed'(val[DW-1:0]));
      REG_KD_OVER_TS: kd_cfg = longint'(signed'(val[DW-1:0]));
      REG_D_ALPHA:    alpha_cfg = longint'(val[FB:0]);
      REG_D_MAX:      dmax_cfg = longint'(val[DW-2:0]);
      REG_OUT_MIN:    omin_cfg = longint'(signed'(val[DW-1:0]));
      REG_OUT_MAX:    omax_cfg = longint'(signed'(val[DW-1:0]));
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] db, kp, ki, kd, alpha, dmax, omin, omax);
    set_reg(REG_DEADBAND, db);
    set_reg(REG_KP, kp);
    set_reg(REG_KI_TS, ki);
    set_reg(REG_KD_OVER_TS, kd);
    set_reg(REG_D_ALPHA, alpha);
    set_reg(REG_D_MAX, dmax);
    set_reg(REG_OUT_MIN, omin);
    set_reg(REG_OUT_MAX, omax);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_error(input logic [31:0] v, input bit drain);
    error_req_t r;
    r.err = v;
    r.drain_first = drain;
    error_queue.push_back(r);
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (error_queue.size() != 0 || expected_out.size() != 0 || in_valid);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h0;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_deadband();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return $urandom & 32'h7FFF_FFFF;
      2: return 32'h7FFF_FFFF;
      default: return $urandom_range(0, 32'h8000);
    endcase
  endfunction

  function automatic logic [31:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return 32'h0001_0000;
      1: return $urandom_range(32'h0001_0001, 32'h0001_FFFF);
      2: return 32'h0;
      default: return $urandom_range(0, 32'h0001_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_dmax();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h0;
      2: return $urandom & 32'h7FFF_FFFF;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  // Slow ramps around the setpoint, plus deadband edges, extreme values and noise
  function automatic logic [31:0] pick_error();
    logic [31:0] tmp;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        tmp = db_cfg[31:0] + $urandom_range(0, 1);
        return $urandom_range(0, 1) ? tmp : -tmp;
      end
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3, 4, 5, 6: begin
        ramp_err = ramp_err + $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
        return ramp_err;
      end
      default: return $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
    endcase
  endfunction

  task automatic random_phase(input int n_items, input bit long_hold);
    logic [31:0] lo, hi, lim;
    int i;
    case ($urandom_range(0, 4))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: begin
        lo = $urandom;
        hi = $urandom;
      end
      2: begin
        lo = -$urandom_range(0, 32'h0010_0000);
        hi = $urandom_range(0, 32'h0040_0000);
      end
      default: begin
        lim = $urandom_range(32'h8000, 32'h0100_0000);
        lo = -lim;
        hi = lim;
      end
    endcase
    load_config(pick_deadband(), pick_gain(), pick_gain(), pick_gain(), pick_alpha(),
                pick_dmax(), lo, hi);
    tx_steady = ($urandom_range(0, 3) == 0) || long_hold;
    rx_steady = ($urandom_range(0, 3) == 0);
    if (long_hold) holds_asked++;
    ramp_err = '0;
    // the middle request waits for every outstanding result
    for (i = 0; i < n_items; i++) queue_error(pick_error(), i == n_items / 2);
    wait_quiet();
  endtask

  // Sender: bursts of random length, random gaps between them unless tx_steady is set
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      error      <= '0;
      gap_left   <= 0;
      burst_left <= 0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        pid_predict(error);
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (error_queue.size() != 0 &&
                     !(error_queue[0].drain_first && expected_out.size() != 0)) begin
          next_req = error_queue.pop_front();
          in_valid <= 1'b1;
          error    <= next_req.err;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= tx_steady ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      rx_left    <= 0;
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
      rx_left   <= $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        note_failure($sformatf("result with nothing pending: drive %h hit %0d",
                               drive, limit_hit));
      end else begin
        want = expected_out.pop_front();
        if (drive !== want.drive || limit_hit !== want.hit)
          note_failure($sformatf("drive exp %h hit %0d, got drive %h hit %0d",
                                 want.drive, want.hit, drive, limit_hit));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pid_controller_antiwindup test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset defaults: all gains zero
    queue_error(32'h0000_0000, 1'b0);
    queue_error(32'h7FFF_FFFF, 1'b0);
    queue_error(32'h8000_0000, 1'b0);
    wait_quiet();

    // widest deadband, saturating gains, alpha above one, zero d_max, crossed limits
    load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h0001_FFFF, 32'h0, 32'h0064_0000, 32'hFF9C_0000);
    queue_error(32'h8000_0000, 1'b0);
    queue_error(32'h7FFF_FFFF, 1'b0);
    queue_error(32'h8000_0000, 1'b0);
    queue_error(32'h8000_0001, 1'b0);
    wait_quiet();

    // ordinary tuning: deadband edges, filtering, clamping at both limits
    load_config(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0001_0000,
                32'h0000_4000, 32'h7FFF_FFFF, 32'hFFFB_0000, 32'h0005_0000);
    queue_error(32'h0001_0000, 1'b0);
    queue_error(32'hFFFF_0000, 1'b0);
    queue_error(32'h0001_0001, 1'b0);
    queue_error(32'hFFFE_FFFF, 1'b0);
    queue_error(32'h0008_0000, 1'b0);
    queue_error(32'h0008_0000, 1'b0);
    queue_error(32'hFFF8_0000, 1'b0);
    queue_error(32'h0000_0000, 1'b0);
    wait_quiet();

    // frozen filter, d_max of one, extreme gains, full range
    load_config(32'h0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_error(32'h7FFF_FFFF, 1'b0);
    queue_error(32'h8000_0000, 1'b0);
    queue_error(32'h0000_0001, 1'b0);
    queue_error(32'hFFFF_FFFF, 1'b0);
    queue_error(32'h5555_5555, 1'b0);
    queue_error(32'hAAAA_AAAA, 1'b0);
    wait_quiet();

    for (ph = 0; ph < 10; ph++) random_phase(70, (ph % 4) == 1);

    if (expected_out.size() != 0) note_failure("results missing at end of run");
    if (fail_count == 0) begin
      $display("pid_controller_antiwindup test passed");
    end else begin
      $display("pid_controller_antiwindup test failed");
    end
    $finish;
  end

endmodule
